FILE: rtl/core/multicolor_char_screen_pixels_defines.svh
// Assertion macros shared by the multicolour character screen RTL.
// Included by any module that carries concurrent checks; depends on nothing.
`ifndef MULTICOLOR_CHAR_SCREEN_PIXELS_DEFINES_SVH
`define MULTICOLOR_CHAR_SCREEN_PIXELS_DEFINES_SVH

// Check a property on every rising edge outside reset
`define MCSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the following edge
`define MCSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mcsp_pkg.sv
// Package for the multicolour character screen: command codes, register
// indexes, store depths, colour set type and the bit-pair colour lookup.
// No dependencies.
package mcsp_pkg;

  // Command codes carried on tuser
  localparam logic [1:0] CMD_CELL   = 2'd0;
  localparam logic [1:0] CMD_BITMAP = 2'd1;
  localparam logic [1:0] CMD_COLOR  = 2'd2;
  localparam logic [1:0] CMD_RENDER = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_BACKGROUND = 2'd0;
  localparam logic [1:0] REG_SHARED_ONE = 2'd1;
  localparam logic [1:0] REG_SHARED_TWO = 2'd2;

  // Register reset values
  localparam logic [3:0] BACKGROUND_RST = 4'd0;
  localparam logic [3:0] SHARED_ONE_RST = 4'd1;
  localparam logic [3:0] SHARED_TWO_RST = 4'd2;

  // Default screen geometry
  localparam int unsigned SCREEN_COLUMNS_DEF = 40;
  localparam int unsigned SCREEN_ROWS_DEF    = 25;

  // Character stores: 256 characters of 8 lines each
  localparam int unsigned BITMAP_DEPTH = 2048;
  localparam int unsigned BITMAP_AW    = 11;
  localparam int unsigned COLOR_DEPTH  = 256;
  localparam int unsigned COLOR_AW     = 8;

  // Pair 11 shows the character colour minus this, modulo 16
  localparam logic [3:0] COLOR_OFFSET = 4'd8;

  // Colours that a bit pair may select
  typedef struct packed {
    logic [3:0] own;
    logic [3:0] shared_two;
    logic [3:0] shared_one;
    logic [3:0] background;
  } palette_t;

  // Map one 2-bit pair onto its palette index
  function automatic logic [3:0] pair_color(logic [1:0] pair, palette_t pal);
    logic [3:0] res;
    case (pair)
      2'b00:   res = pal.background;
      2'b01:   res = pal.shared_one;
      2'b10:   res = pal.shared_two;
      default: res = pal.own - COLOR_OFFSET;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/mcsp_color_map.sv
// Output stage: turns one bitmap byte into four double-pixel colours and
// holds them in the output register until the master side takes them.
// Depends on mcsp_pkg.
module mcsp_color_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              oob_i,
  input  logic [7:0]        bits_i,
  input  mcsp_pkg::palette_t pal_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pixel_color_0 [3:0], pixel_color_1 [7:4], pixel_color_2 [11:8], pixel_color_3 [15:12]
  output logic [15:0]       m_axis_tdata
);
  import mcsp_pkg::*;

  logic        valid_q, valid_d;
  logic [15:0] data_q, data_d;
  logic [7:0]  bits;

  // Cells off the screen show background in every pixel
  assign bits = oob_i ? 8'h00 : bits_i;

  // Leftmost pixel comes from the top pair
  always_comb begin
    data_d = data_q;
    if (load_i) begin
      for (int j = 0; j < 4; j++) begin
        data_d[4*j +: 4] = pair_color(bits[6 - 2*j +: 2], pal_i);
      end
    end
  end

  assign free_o = !valid_q || m_axis_tready;

  // Hold the result until the transaction completes
  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

FILE: rtl/core/multicolor_char_screen_pixels.sv
// Channel     | dir | handshake               | payload
// s_axis      | in  | s_axis_tvalid/tready    | tuser command, tdata cell/char/line/data
// m_axis      | out | m_axis_tvalid/tready    | tdata four pixel colours
// cfg         | in  | cfg_we_i (no stall)     | cfg_idx_i, cfg_data_i
//
// A write command is stored in the cycle it is accepted. A render steps
// through a screen read, then bitmap and colour reads, then the colour
// map into the output register. One item is in flight at a time; the
// next is taken once it has finished. After reset a clearing pass zeroes
// all three stores; no item is accepted during it.
// A render stalls in its last step while the output register is full.
// Depends on mcsp_pkg, mcsp_color_map and the shared assertion macros.
`include "multicolor_char_screen_pixels_defines.svh"

module multicolor_char_screen_pixels #(
  parameter int unsigned SCREEN_COLUMNS = mcsp_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = mcsp_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column [5:0], row [10:6], char_code [18:11], line [21:19], data_value [29:22]
  input  logic [31:0] s_axis_tdata,
  // command [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color_0 [3:0], pixel_color_1 [7:4], pixel_color_2 [11:8], pixel_color_3 [15:12]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);
  import mcsp_pkg::*;

  localparam int unsigned CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CLR_LEN = (CELLS > BITMAP_DEPTH) ? CELLS : BITMAP_DEPTH;
  // Wide enough to hold the store depths themselves for the limit compares
  localparam int unsigned CLR_W   = $clog2(CLR_LEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CODE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  // Input fields
  logic [5:0] in_col;
  logic [4:0] in_row;
  logic [7:0] in_code;
  logic [2:0] in_line;
  logic [7:0] in_data;
  assign in_col  = s_axis_tdata[5:0];
  assign in_row  = s_axis_tdata[10:6];
  assign in_code = s_axis_tdata[18:11];
  assign in_line = s_axis_tdata[21:19];
  assign in_data = s_axis_tdata[29:22];

  logic [1:0]  state_q, state_d;
  logic        clearing_q;
  logic [CLR_W-1:0] clr_cnt_q;
  logic [3:0]  bg_q, c1_q, c2_q;
  logic [2:0]  line_q;
  logic        oob_q;
  logic        in_fire, in_range, out_free, load;
  logic [CELL_AW-1:0] cell_idx;

  // Stores and their ports
  logic [7:0] scr_mem [CELLS];
  logic [7:0] bm_mem  [BITMAP_DEPTH];
  logic [3:0] col_mem [COLOR_DEPTH];
  logic                 scr_we, scr_re, bm_we, bm_re, col_we, col_re;
  logic [CELL_AW-1:0]   scr_wa;
  logic [BITMAP_AW-1:0] bm_wa;
  logic [COLOR_AW-1:0]  col_wa;
  logic [7:0]           scr_wd, bm_wd;
  logic [3:0]           col_wd;
  logic [7:0]           scr_rd_q, bm_rd_q;
  logic [3:0]           col_rd_q;
  palette_t             pal;

  assign s_axis_tready = (state_q == ST_IDLE) && !clearing_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_range      = (7'(in_col) < 7'(SCREEN_COLUMNS)) && (7'(in_row) < 7'(SCREEN_ROWS));
  assign cell_idx      = CELL_AW'(CELL_AW'(in_row) * CELL_AW'(SCREEN_COLUMNS))
                         + CELL_AW'(in_col);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= BACKGROUND_RST;
      c1_q <= SHARED_ONE_RST;
      c2_q <= SHARED_TWO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BACKGROUND: bg_q <= cfg_data_i;
        REG_SHARED_ONE: c1_q <= cfg_data_i;
        REG_SHARED_TWO: c2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CLR_W'(CLR_LEN - 1)) clearing_q <= 1'b0;
    end
  end

  // Write ports: clearing pass or write commands
  always_comb begin
    scr_we = 1'b0;
    scr_wa = cell_idx;
    scr_wd = in_code;
    bm_we  = 1'b0;
    bm_wa  = {in_code, in_line};
    bm_wd  = in_data;
    col_we = 1'b0;
    col_wa = in_code;
    col_wd = in_data[3:0];
    if (clearing_q) begin
      scr_we = clr_cnt_q < CLR_W'(CELLS);
      scr_wa = clr_cnt_q[CELL_AW-1:0];
      scr_wd = '0;
      bm_we  = clr_cnt_q < CLR_W'(BITMAP_DEPTH);
      bm_wa  = clr_cnt_q[BITMAP_AW-1:0];
      bm_wd  = '0;
      col_we = clr_cnt_q < CLR_W'(COLOR_DEPTH);
      col_wa = clr_cnt_q[COLOR_AW-1:0];
      col_wd = '0;
    end else if (in_fire) begin
      case (s_axis_tuser)
        CMD_CELL:   scr_we = in_range;
        CMD_BITMAP: bm_we  = 1'b1;
        CMD_COLOR:  col_we = 1'b1;
        default: ;
      endcase
    end
  end

  // Read enables: screen on render accept, character stores in the cycle after
  assign scr_re = in_fire && (s_axis_tuser == CMD_RENDER) && in_range;
  assign bm_re  = (state_q == ST_CODE);
  assign col_re = (state_q == ST_CODE);

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    if (scr_re) scr_rd_q <= scr_mem[cell_idx];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (bm_re) bm_rd_q <= bm_mem[{scr_rd_q, line_q}];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    if (col_re) col_rd_q <= col_mem[scr_rd_q];
  end

  // Render sequencer
  assign load = (state_q == ST_FETCH) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && (s_axis_tuser == CMD_RENDER)) state_d = ST_CODE;
      ST_CODE:  state_d = ST_FETCH;
      ST_FETCH: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold render context
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_q <= in_line;
      oob_q  <= !in_range;
    end
  end

  assign pal = '{own: col_rd_q, shared_two: c2_q, shared_one: c1_q, background: bg_q};

  mcsp_color_map u_color_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .oob_i         (oob_q),
    .bits_i        (bm_rd_q),
    .pal_i         (pal),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `MCSP_ASSERT(a_no_accept_clearing, clk_i, rst_ni, clearing_q |-> !s_axis_tready, "accept during clearing pass")
  `MCSP_ASSERT_NEXT(a_render_starts, clk_i, rst_ni, in_fire && (s_axis_tuser == CMD_RENDER), state_q == ST_CODE, "render did not start")
  `MCSP_ASSERT_NEXT(a_write_one_cycle, clk_i, rst_ni, in_fire && (s_axis_tuser != CMD_RENDER), state_q == ST_IDLE, "write left idle")
  `MCSP_ASSERT_NEXT(a_code_to_fetch, clk_i, rst_ni, state_q == ST_CODE, state_q == ST_FETCH, "character fetch skipped")
  `MCSP_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, load, m_axis_tvalid && (state_q == ST_IDLE), "result not presented")

endmodule
